FILE: rtl/acs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the contextual shaper.
// No dependencies; used by acs_glyph_fifo and arabic_contextual_shaper.
package acs_pkg;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } t_glyph;

    localparam logic [15:0] LETTER_FIRST = 16'h0621;
    localparam logic [15:0] LETTER_LAST  = 16'h064a;
    localparam logic [15:0] ASCII_LIMIT  = 16'h0080;
    localparam logic [15:0] LAM_CODE     = 16'h0644;
    localparam logic [15:0] ALEF_MADDA   = 16'h0622;
    localparam logic [15:0] ALEF_HAMZA_A = 16'h0623;
    localparam logic [15:0] ALEF_HAMZA_B = 16'h0625;
    localparam logic [15:0] ALEF_PLAIN   = 16'h0627;
    localparam logic [15:0] LIG_MADDA    = 16'hfef5;
    localparam logic [15:0] LIG_HAMZA_A  = 16'hfef7;
    localparam logic [15:0] LIG_HAMZA_B  = 16'hfef9;
    localparam logic [15:0] LIG_PLAIN    = 16'hfefb;

    // Form column codes
    localparam logic [1:0] COL_PREV    = 2'd0;
    localparam logic [1:0] COL_NEXT    = 2'd1;
    localparam logic [1:0] COL_BOTH    = 2'd2;
    localparam logic [1:0] COL_NEITHER = 2'd3;

    localparam int ROM_ROWS = 42;

    // One row per letter; columns prev-only, next-only, both, neither from the top bits down
    localparam logic [63:0] FORM_ROM [0:ROM_ROWS-1] = '{
        64'hfe80_fe80_fe80_fe80, 64'hfe82_fe81_fe82_fe81,
        64'hfe84_fe83_fe84_fe83, 64'hfe86_fe85_fe86_fe85,
        64'hfe88_fe87_fe88_fe87, 64'hfe8a_fe8b_fe8c_fe89,
        64'hfe8e_fe8d_fe8e_fe8d, 64'hfe90_fe91_fe92_fe8f,
        64'hfe94_fe93_fe94_fe93, 64'hfe96_fe97_fe98_fe95,
        64'hfe9a_fe9b_fe9c_fe99, 64'hfe9e_fe9f_fea0_fe9d,
        64'hfea2_fea3_fea4_fea1, 64'hfea6_fea7_fea8_fea5,
        64'hfeaa_fea9_feaa_fea9, 64'hfeac_feab_feac_feab,
        64'hfeae_fead_feae_fead, 64'hfeb0_feaf_feb0_feaf,
        64'hfeb2_feb3_feb4_feb1, 64'hfeb6_feb7_feb8_feb5,
        64'hfeba_febb_febc_feb9, 64'hfebe_febf_fec0_febd,
        64'hfec2_fec3_fec4_fec1, 64'hfec6_fec7_fec8_fec5,
        64'hfeca_fecb_fecc_fec9, 64'hfece_fecf_fed0_fecd,
        64'h063b_063b_063b_063b, 64'h063c_063c_063c_063c,
        64'h063d_063d_063d_063d, 64'h063e_063e_063e_063e,
        64'h063f_063f_063f_063f, 64'h0640_0640_0640_0640,
        64'hfed2_fed3_fed4_fed1, 64'hfed6_fed7_fed8_fed5,
        64'hfeda_fedb_fedc_fed9, 64'hfede_fedf_fee0_fedd,
        64'hfee2_fee3_fee4_fee1, 64'hfee6_fee7_fee8_fee5,
        64'hfeea_feeb_feec_fee9, 64'hfeee_feed_feee_feed,
        64'hfef0_feef_fef0_feef, 64'hfef2_fef3_fef4_fef1
    };

    function automatic logic is_dual(input logic [15:0] c);
        logic r;
        case (c) inside
            16'h062c, 16'h062d, 16'h062e, 16'h0647, 16'h0639, 16'h063a,
            16'h0641, 16'h0642, 16'h062b, 16'h0635, 16'h0636, 16'h0637,
            16'h0643, 16'h0645, 16'h0646, 16'h062a, 16'h0644, 16'h0628,
            16'h064a, 16'h0633, 16'h0634, 16'h0638, 16'h0626: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_join(input logic [15:0] c);
        logic r;
        case (c) inside
            16'h0627, 16'h0623, 16'h0625, 16'h0622, 16'h062f, 16'h0630,
            16'h0631, 16'h0632, 16'h0648, 16'h0624, 16'h0629, 16'h0649: r = 1'b1;
            default: r = is_dual(c);
        endcase
        return r;
    endfunction

    // Ligature base for an alef after lam; zero means no ligature
    function automatic logic [15:0] lig_base(input logic [15:0] c);
        logic [15:0] r;
        unique case (c)
            ALEF_MADDA:   r = LIG_MADDA;
            ALEF_HAMZA_A: r = LIG_HAMZA_A;
            ALEF_HAMZA_B: r = LIG_HAMZA_B;
            ALEF_PLAIN:   r = LIG_PLAIN;
            default:      r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] shape(input logic [15:0] c, input logic back,
                                          input logic fwd);
        logic [15:0] offs;
        logic [5:0]  row;
        logic [1:0]  col;
        logic [63:0] word;
        logic [15:0] r;
        offs = c - LETTER_FIRST;
        row  = offs[5:0];
        if (back) begin
            col = fwd ? COL_BOTH : COL_PREV;
        end else begin
            col = fwd ? COL_NEXT : COL_NEITHER;
        end
        if (c < ASCII_LIMIT || c < LETTER_FIRST || c > LETTER_LAST) begin
            r = c;
        end else begin
            word = FORM_ROM[row];
            r = word[(2'd3 - col) * 16 +: 16];
        end
        return r;
    endfunction

endpackage

FILE: rtl/acs_glyph_fifo.sv
`timescale 1ns / 1ps
// Four-entry glyph queue taking up to two words per cycle and giving one.
// Depends on acs_pkg for the glyph word type.
module acs_glyph_fifo
    import acs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push0,
    input  logic   i_push1,
    input  t_glyph i_data0,
    input  t_glyph i_data1,
    output logic   o_room2,
    output logic   o_valid,
    output t_glyph o_data,
    input  logic   i_pop
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_glyph           r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             pop_ok;
    logic [AW-1:0]    wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= (AW + 1)'(DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;
    assign wr_ptr1 = r_wr_ptr + AW'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push0) + AW'(i_push1);
        n_rd_ptr = r_rd_ptr + AW'(pop_ok);
        n_count  = r_count + (AW + 1)'(i_push0) + (AW + 1)'(i_push1) - (AW + 1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

endmodule

FILE: rtl/arabic_contextual_shaper.sv
`timescale 1ns / 1ps
// Top level of the Arabic contextual shaper: lookahead state and shaping logic.
// Depends on acs_pkg and acs_glyph_fifo.
//
// Input channel: i_valid / o_stall carry one UTF-16 code point per word with
// an end-of-string mark. Output channel: o_valid / i_stall carry one glyph per
// word with a last-glyph mark. A word moves when valid is high and stall low.
// Shaping needs one code point of lookahead, so a glyph is written to the output
// queue when the word that completes its context is taken; the final code point
// of a string releases the held glyph and its own together. A lam followed
// by an alef yields one ligature word and the alef yields none.
// Throughput: one code point per cycle while o_stall is low. Results land in a
// four-entry queue; o_stall rises when fewer than two entries are free, so a
// stalled receiver backs up into the input. Reset (synchronous, active low)
// clears the lookahead state and empties the queue.
module arabic_contextual_shaper
    import acs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_point,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_glyph_code,
    output logic        o_last_glyph
);

    logic [15:0] r_prev, n_prev;
    logic [15:0] r_pend, n_pend;
    logic        r_pend_valid, n_pend_valid;

    logic        in_acc;
    logic        room2;
    logic        push0, push1;
    t_glyph      data0, data1, head;
    logic [15:0] base;
    logic        prev_dual;

    assign o_stall = !room2;
    assign in_acc  = i_valid && room2;

    always_comb begin
        n_prev       = r_prev;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        push0        = 1'b0;
        push1        = 1'b0;
        base         = lig_base(i_code_point);
        prev_dual    = is_dual(r_prev);
        data0.code   = shape(i_code_point, prev_dual, 1'b0);
        data0.last   = 1'b1;
        data1.code   = shape(i_code_point, is_dual(r_pend), 1'b0);
        data1.last   = 1'b1;
        if (in_acc) begin
            if (r_pend_valid) begin
                push0 = 1'b1;
                if (r_pend == LAM_CODE && base != 16'h0000) begin
                    // lam-alef: swallow the alef, it becomes the predecessor
                    data0.code   = base + 16'(prev_dual);
                    data0.last   = i_end_of_string;
                    n_pend_valid = 1'b0;
                    n_pend       = '0;
                    n_prev       = i_end_of_string ? 16'h0000 : i_code_point;
                end else begin
                    data0.code = shape(r_pend, prev_dual, is_join(i_code_point));
                    data0.last = 1'b0;
                    if (i_end_of_string) begin
                        push1        = 1'b1;
                        n_prev       = '0;
                        n_pend       = '0;
                        n_pend_valid = 1'b0;
                    end else begin
                        n_prev = r_pend;
                        n_pend = i_code_point;
                    end
                end
            end else if (i_end_of_string) begin
                push0        = 1'b1;
                n_prev       = '0;
                n_pend       = '0;
                n_pend_valid = 1'b0;
            end else begin
                n_pend       = i_code_point;
                n_pend_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_prev       <= n_prev;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
        end
    end

    acs_glyph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_room2 (room2),
        .o_valid (o_valid),
        .o_data  (head),
        .i_pop   (!i_stall)
    );

    assign o_glyph_code = head.code;
    assign o_last_glyph = head.last;

endmodule
